[rtl/ordered_keyed_list_table_unit_assert.svh]
// ---------------------------------------------------------------------------
// Ordered keyed list table assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef ORDERED_KEYED_LIST_TABLE_UNIT_ASSERT_SVH
`define ORDERED_KEYED_LIST_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define OKLT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OKLT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/oklt_pkg.sv]
// ---------------------------------------------------------------------------
// Ordered keyed list table package
// Shared widths, request and status codes, and the cell control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package oklt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int KEY_WIDTH       = 32;
	localparam int PAYLOAD_WIDTH   = 32;
	localparam int OP_WIDTH        = 3;
	localparam int STATUS_WIDTH    = 2;

	localparam logic [OP_WIDTH-1:0] OP_APPEND        = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_APPEND_ABSENT = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_SEARCH        = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_DELETE        = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_READ_HEAD     = 3'd4;

	localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_PRESENT   = 2'd3;

	typedef struct packed {
		logic cmp;
		logic commit_append;
		logic commit_delete;
	} oklt_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/oklt_cell.sv]
// ---------------------------------------------------------------------------
// Ordered keyed list table cell
// One slot: key, data, valid and match flag, with first-match and result
// chains to the neighbors and shift-up on delete.
// ---------------------------------------------------------------------------
`default_nettype none

module oklt_cell #(
	parameter int DATA_WIDTH = oklt_pkg::DATA_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  oklt_pkg::oklt_cell_ctrl_t    ctrl,
	input  wire [oklt_pkg::KEY_WIDTH-1:0] cmp_key,
	input  wire [oklt_pkg::KEY_WIDTH-1:0] wr_key,
	input  wire [DATA_WIDTH-1:0]         wr_data,
	input  wire                          prev_valid,
	input  wire                          hit_in,
	input  wire [oklt_pkg::KEY_WIDTH-1:0] sel_key_in,
	input  wire [DATA_WIDTH-1:0]         sel_data_in,
	input  wire                          next_valid,
	input  wire [oklt_pkg::KEY_WIDTH-1:0] next_key,
	input  wire [DATA_WIDTH-1:0]         next_data,
	output logic                         hit_out,
	output logic [oklt_pkg::KEY_WIDTH-1:0] sel_key_out,
	output logic [DATA_WIDTH-1:0]        sel_data_out,
	output logic                         cell_valid,
	output logic [oklt_pkg::KEY_WIDTH-1:0] cell_key,
	output logic [DATA_WIDTH-1:0]        cell_data
);
	import oklt_pkg::*;

	logic                  valid_q;
	logic                  hit_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  first;
	logic                  is_tail;
	logic                  shift;

	assign first        = hit_q & ~hit_in;
	assign hit_out      = hit_in | hit_q;
	assign sel_key_out  = sel_key_in | (first ? key_q : '0);
	assign sel_data_out = sel_data_in | (first ? data_q : '0);
	assign is_tail      = prev_valid & ~valid_q;
	assign shift        = ctrl.commit_delete & (hit_in | hit_q);

	assign cell_valid = valid_q;
	assign cell_key   = key_q;
	assign cell_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				hit_q <= valid_q & (key_q == cmp_key);
			end
			if (ctrl.commit_append && is_tail) begin
				valid_q <= 1'b1;
			end else if (shift) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit_append && is_tail) begin
			key_q  <= wr_key;
			data_q <= wr_data;
		end else if (shift) begin
			key_q  <= next_key;
			data_q <= next_data;
		end
	end

endmodule

`default_nettype wire

[rtl/ordered_keyed_list_table_unit.sv]
// ---------------------------------------------------------------------------
// Ordered keyed list table unit
// Bounded insertion-ordered table of keyed entries held in a row of cells.
// ---------------------------------------------------------------------------
// Each item passes through the idle and execute states: in the cycle it is
// accepted every cell compares its key with the request key; then, in the
// execute state, the first match is resolved along the cell chain, the table
// is updated (append at the tail, or later cells shift up one place on
// delete) and the result is loaded into the output register. A new item is
// accepted in the cycle after that while the previous result still waits;
// if the result is not taken the execute state holds until the output register frees up.
`default_nettype none

module ordered_keyed_list_table_unit #(
	parameter int TABLE_DEPTH = oklt_pkg::TABLE_DEPTH_DEF,
	parameter int DATA_WIDTH  = oklt_pkg::DATA_WIDTH_DEF,
	parameter int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1)
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [oklt_pkg::OP_WIDTH-1:0]    op,
	input  wire [oklt_pkg::KEY_WIDTH-1:0]   key,
	input  wire [oklt_pkg::PAYLOAD_WIDTH-1:0] payload,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [oklt_pkg::STATUS_WIDTH-1:0] status,
	output logic                            found,
	output logic [oklt_pkg::KEY_WIDTH-1:0]  out_key,
	output logic [oklt_pkg::PAYLOAD_WIDTH-1:0] out_payload,
	output logic [CNT_WIDTH-1:0]            entry_count,
	output logic                            is_empty
);
	import oklt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                    state_q;
	logic [OP_WIDTH-1:0]       req_op_q;
	logic [KEY_WIDTH-1:0]      req_key_q;
	logic [DATA_WIDTH-1:0]     req_data_q;
	logic [CNT_WIDTH-1:0]      count_q;

	logic                      out_valid_q;
	logic [STATUS_WIDTH-1:0]   status_q;
	logic                      found_q;
	logic [KEY_WIDTH-1:0]      out_key_q;
	logic [PAYLOAD_WIDTH-1:0]  out_payload_q;
	logic [CNT_WIDTH-1:0]      entry_count_q;
	logic                      is_empty_q;

	logic                      accept;
	logic                      commit;
	oklt_cell_ctrl_t           ctrl;

	logic [TABLE_DEPTH:0]      hit_c;
	logic [TABLE_DEPTH-1:0]    valid_v;
	logic [KEY_WIDTH-1:0]      key_v     [TABLE_DEPTH];
	logic [DATA_WIDTH-1:0]     data_v    [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0]      sel_key_c [TABLE_DEPTH+1];
	logic [DATA_WIDTH-1:0]     sel_data_c[TABLE_DEPTH+1];

	logic                      any_hit;
	logic                      full;
	logic                      do_append;
	logic                      do_delete;
	logic [STATUS_WIDTH-1:0]   nx_status;
	logic                      nx_found;
	logic [KEY_WIDTH-1:0]      nx_key;
	logic [PAYLOAD_WIDTH-1:0]  nx_payload;
	logic [CNT_WIDTH-1:0]      nx_count;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign commit   = (state_q == S_EXEC) & (~out_valid_q | out_ready);

	assign hit_c[0]      = 1'b0;
	assign sel_key_c[0]  = '0;
	assign sel_data_c[0] = '0;
	assign any_hit       = hit_c[TABLE_DEPTH];
	assign full          = valid_v[TABLE_DEPTH-1];

	assign ctrl.cmp           = accept;
	assign ctrl.commit_append = commit & do_append;
	assign ctrl.commit_delete = commit & do_delete;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic                  prev_valid;
		logic                  next_valid;
		logic [KEY_WIDTH-1:0]  next_key;
		logic [DATA_WIDTH-1:0] next_data;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_valid = valid_v[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_key   = '0;
			assign next_data  = '0;
		end else begin : g_inner
			assign next_valid = valid_v[i+1];
			assign next_key   = key_v[i+1];
			assign next_data  = data_v[i+1];
		end

		oklt_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cmp_key     (key),
			.wr_key      (req_key_q),
			.wr_data     (req_data_q),
			.prev_valid  (prev_valid),
			.hit_in      (hit_c[i]),
			.sel_key_in  (sel_key_c[i]),
			.sel_data_in (sel_data_c[i]),
			.next_valid  (next_valid),
			.next_key    (next_key),
			.next_data   (next_data),
			.hit_out     (hit_c[i+1]),
			.sel_key_out (sel_key_c[i+1]),
			.sel_data_out(sel_data_c[i+1]),
			.cell_valid  (valid_v[i]),
			.cell_key    (key_v[i]),
			.cell_data   (data_v[i])
		);
	end

	always_comb begin
		do_append  = 1'b0;
		do_delete  = 1'b0;
		nx_status  = ST_DONE;
		nx_found   = 1'b0;
		nx_key     = '0;
		nx_payload = '0;
		case (req_op_q)
			OP_APPEND: begin
				if (full) begin
					nx_status = ST_FULL;
				end else begin
					do_append = 1'b1;
				end
			end
			OP_APPEND_ABSENT: begin
				if (any_hit) begin
					nx_status  = ST_PRESENT;
					nx_found   = 1'b1;
					nx_key     = sel_key_c[TABLE_DEPTH];
					nx_payload = PAYLOAD_WIDTH'(sel_data_c[TABLE_DEPTH]);
				end else if (full) begin
					nx_status = ST_FULL;
				end else begin
					do_append = 1'b1;
				end
			end
			OP_SEARCH, OP_DELETE: begin
				if (any_hit) begin
					nx_found   = 1'b1;
					nx_key     = sel_key_c[TABLE_DEPTH];
					nx_payload = PAYLOAD_WIDTH'(sel_data_c[TABLE_DEPTH]);
					do_delete  = (req_op_q == OP_DELETE);
				end else begin
					nx_status = ST_NOT_FOUND;
				end
			end
			OP_READ_HEAD: begin
				if (valid_v[0]) begin
					nx_found   = 1'b1;
					nx_key     = key_v[0];
					nx_payload = PAYLOAD_WIDTH'(data_v[0]);
				end else begin
					nx_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		if (do_append) begin
			nx_count = count_q + CNT_WIDTH'(1);
		end else if (do_delete) begin
			nx_count = count_q - CNT_WIDTH'(1);
		end else begin
			nx_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= nx_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q   <= op;
			req_key_q  <= key;
			req_data_q <= DATA_WIDTH'(payload);
		end
		if (commit) begin
			status_q      <= nx_status;
			found_q       <= nx_found;
			out_key_q     <= nx_key;
			out_payload_q <= nx_payload;
			entry_count_q <= nx_count;
			is_empty_q    <= (nx_count == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

`include "ordered_keyed_list_table_unit_assert.svh"

	`OKLT_ASSERT_IMP(a_count_matches_cells, 1'b1, $countones(valid_v) == int'(count_q),
		"held count disagrees with valid cells")
	`OKLT_ASSERT_IMP(a_cells_packed, 1'b1, ((valid_v + TABLE_DEPTH'(1)) & valid_v) == '0,
		"valid cells are not packed from the head")
	`OKLT_ASSERT_NXT(a_accept_to_exec, accept, state_q == S_EXEC,
		"accepted item did not move to execute")
	`OKLT_ASSERT_IMP(a_found_status, out_valid_q && found_q,
		status_q == ST_DONE || status_q == ST_PRESENT,
		"found result with failure status")

endmodule

`default_nettype wire

[bench/ordered_keyed_list_table_unit_tb.sv]
// ---------------------------------------------------------------------------
// Ordered keyed list table unit testbench
// Drives append, conditional append, search, delete and head-read items
// through the valid/ready request port, predicts every result with a
// packed-slot copy of the table and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_keyed_list_table_unit_tb;

	import oklt_pkg::*;

	localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [OP_WIDTH-1:0]      op;
		logic [KEY_WIDTH-1:0]     key;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} table_req_t;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0]  status;
		logic                     found;
		logic [KEY_WIDTH-1:0]     key;
		logic [PAYLOAD_WIDTH-1:0] payload;
		logic [4:0]               count;
		logic                     empty;
	} table_rsp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_WIDTH-1:0]      op = '0;
	logic [KEY_WIDTH-1:0]     key = '0;
	logic [PAYLOAD_WIDTH-1:0] payload = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STATUS_WIDTH-1:0]  status;
	logic                     found;
	logic [KEY_WIDTH-1:0]     out_key;
	logic [PAYLOAD_WIDTH-1:0] out_payload;
	logic [4:0]               entry_count;
	logic                     is_empty;

	table_req_t               req_queue[$];
	table_rsp_t               rsp_expected[$];
	logic [KEY_WIDTH-1:0]     model_key[TBL_DEPTH];
	logic [PAYLOAD_WIDTH-1:0] model_data[TBL_DEPTH];
	int                       model_count = 0;
	int                       send_idle_pct = 11;
	int                       recv_idle_pct = 71;
	int                       err_count = 0;
	int                       cycle_count = 0;

	ordered_keyed_list_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.payload    (payload),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found      (found),
		.out_key    (out_key),
		.out_payload(out_payload),
		.entry_count(entry_count),
		.is_empty   (is_empty)
	);

	always #5 clk = ~clk;

	function automatic void predict_table_rsp(input table_req_t req);
		table_rsp_t rsp;
		int idx;
		rsp = '0;
		idx = -1;
		for (int i = 0; i < model_count; i++)
			if (idx < 0 && model_key[i] == req.key)
				idx = i;
		case (req.op)
			OP_APPEND, OP_APPEND_ABSENT: begin
				if (req.op == OP_APPEND_ABSENT && idx >= 0) begin
					rsp.status  = ST_PRESENT;
					rsp.found   = 1'b1;
					rsp.key     = model_key[idx];
					rsp.payload = model_data[idx];
				end else if (model_count < TBL_DEPTH) begin
					model_key[model_count]  = req.key;
					model_data[model_count] = req.payload;
					model_count++;
				end else begin
					rsp.status = ST_FULL;
				end
			end
			OP_SEARCH, OP_DELETE: begin
				if (idx >= 0) begin
					rsp.found   = 1'b1;
					rsp.key     = model_key[idx];
					rsp.payload = model_data[idx];
					if (req.op == OP_DELETE) begin
						for (int i = idx; i + 1 < model_count; i++) begin
							model_key[i]  = model_key[i + 1];
							model_data[i] = model_data[i + 1];
						end
						model_count--;
					end
				end else begin
					rsp.status = ST_NOT_FOUND;
				end
			end
			OP_READ_HEAD: begin
				if (model_count > 0) begin
					rsp.found   = 1'b1;
					rsp.key     = model_key[0];
					rsp.payload = model_data[0];
				end else begin
					rsp.status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		rsp.count = 5'(model_count);
		rsp.empty = (model_count == 0);
		rsp_expected.push_back(rsp);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic add_req(input logic [OP_WIDTH-1:0] r_op, input logic [KEY_WIDTH-1:0] r_key,
			input logic [PAYLOAD_WIDTH-1:0] r_payload);
		req_queue.push_back('{op: r_op, key: r_key, payload: r_payload});
	endtask

	task automatic gen_random(input int n);
		logic [KEY_WIDTH-1:0] pool[6];
		logic [OP_WIDTH-1:0]  r_op;
		logic [KEY_WIDTH-1:0] r_key;
		int grow;
		int pick;
		grow = 1;
		for (int j = 0; j < 6; j++)
			pool[j] = $urandom;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				grow = $urandom_range(1);
			if (i % 300 == 299)
				for (int j = 0; j < 6; j++)
					pool[j] = $urandom;
			pick = $urandom_range(99);
			if (grow)
				r_op = pick < 50 ? OP_APPEND : pick < 70 ? OP_APPEND_ABSENT :
					pick < 80 ? OP_SEARCH : pick < 90 ? OP_DELETE :
					pick < 96 ? OP_READ_HEAD : 3'($urandom_range(7, 5));
			else
				r_op = pick < 15 ? OP_APPEND : pick < 25 ? OP_APPEND_ABSENT :
					pick < 45 ? OP_SEARCH : pick < 88 ? OP_DELETE :
					pick < 96 ? OP_READ_HEAD : 3'($urandom_range(7, 5));
			r_key = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(5)];
			add_req(r_op, r_key, $urandom);
		end
	endtask

	task automatic wait_drain();
		while (req_queue.size() != 0 || in_valid || rsp_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= '0;
			key      <= '0;
			payload  <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_table_rsp('{op: op, key: key, payload: payload});
			if (!in_valid || in_ready) begin
				if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					op       <= req_queue[0].op;
					key      <= req_queue[0].key;
					payload  <= req_queue[0].payload;
					req_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rsp_expected.size() == 0) begin
					report_mismatch("unexpected result", {30'd0, status}, '0);
				end else begin
					if (status !== rsp_expected[0].status)
						report_mismatch("status", {30'd0, status}, {30'd0, rsp_expected[0].status});
					if (found !== rsp_expected[0].found)
						report_mismatch("found", {31'd0, found}, {31'd0, rsp_expected[0].found});
					if (out_key !== rsp_expected[0].key)
						report_mismatch("out_key", out_key, rsp_expected[0].key);
					if (out_payload !== rsp_expected[0].payload)
						report_mismatch("out_payload", out_payload, rsp_expected[0].payload);
					if (entry_count !== rsp_expected[0].count)
						report_mismatch("entry_count", {27'd0, entry_count},
							{27'd0, rsp_expected[0].count});
					if (is_empty !== rsp_expected[0].empty)
						report_mismatch("is_empty", {31'd0, is_empty}, {31'd0, rsp_expected[0].empty});
					rsp_expected.pop_front();
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ordered_keyed_list_table_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_req(OP_READ_HEAD, $urandom, $urandom);
		add_req(OP_DELETE, 32'h0, $urandom);
		add_req(OP_APPEND, 32'h0, 32'h0);
		add_req(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(OP_APPEND_ABSENT, 32'h0, $urandom);
		add_req(OP_APPEND_ABSENT, 32'h1234_5678, $urandom);
		add_req(OP_APPEND, 32'h0, $urandom);
		add_req(OP_SEARCH, 32'h0, $urandom);
		add_req(OP_DELETE, 32'h0, $urandom);
		add_req(OP_READ_HEAD, $urandom, $urandom);
		add_req(3'd5, $urandom, $urandom);
		add_req(3'd6, $urandom, $urandom);
		add_req(3'd7, $urandom, $urandom);
		for (int i = 0; i < TBL_DEPTH - 3; i++)
			add_req(OP_APPEND, $urandom, $urandom);
		add_req(OP_APPEND, $urandom, $urandom);
		add_req(OP_APPEND_ABSENT, 32'hA5A5_5A5A, $urandom);
		wait_drain();

		gen_random(500);
		wait_drain();

		send_idle_pct = 71;
		recv_idle_pct = 11;
		gen_random(500);
		wait_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_random(500);
		wait_drain();

		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("ordered_keyed_list_table_unit_tb OK");
		else
			$display("ordered_keyed_list_table_unit_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/oklt_pkg.sv
rtl/oklt_cell.sv
rtl/ordered_keyed_list_table_unit.sv
bench/ordered_keyed_list_table_unit_tb.sv
